// ===== hdl/ksh_pkg.sv =====
// Shared types, constants and functions for the Keccak sponge hash block.
`timescale 1ns / 1ps
`default_nettype none
package ksh_pkg;

    localparam int ROUNDS_DEFAULT = 24;
    localparam logic [7:0] RATE_RESET   = 8'd136;
    localparam logic [7:0] SUFFIX_RESET = 8'd6;
    localparam logic [6:0] DIGEST_RESET = 7'd32;
    localparam logic [7:0] LFSR_POLY    = 8'h71;
    localparam logic [7:0] LFSR_SEED    = 8'h01;
    localparam logic [7:0] PAD_TOP      = 8'h80;
    localparam logic [7:0] DELIM_DEFAULT = 8'h01;
    localparam logic [7:0] STATE_BYTES  = 8'd200;
    localparam logic [6:0] DIGEST_MAX   = 7'd64;

    localparam logic [1:0] CFG_RATE   = 2'd0;
    localparam logic [1:0] CFG_SUFFIX = 2'd1;
    localparam logic [1:0] CFG_DIGEST = 2'd2;

    typedef logic [1599:0] state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE_PERM,
        ST_ABSORB,
        ST_POST_PERM,
        ST_PAD_PRE,
        ST_PAD_SUFFIX,
        ST_PAD_EXTRA,
        ST_PAD_FINAL,
        ST_SQ_PERM,
        ST_SQ_OUT,
        ST_CLEAR
    } ctrl_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       xor_en;     // xor xor_val at byte xor_pos
        logic [7:0] xor_pos;
        logic [7:0] xor_val;
        logic       top_en;     // flip top bit of the rate
        logic       perm_start;
        logic       clear;
    } dp_cmd_t;

    typedef struct packed {
        logic       perm_busy;
        logic [7:0] read_data;
    } dp_status_t;

    function automatic logic [63:0] rotl(input logic [63:0] v, input int n);
        rotl = (n == 0) ? v : ((v << n) | (v >> (64 - n)));
    endfunction

    function automatic int lidx(input int x, input int y);
        lidx = 5 * y + x;
    endfunction

    // Rho rotation per lane index.
    function automatic int rho_off(input int i);
        int t [25];
        t = '{0, 1, 62, 28, 27, 36, 44, 6, 55, 20, 3, 10, 43, 25, 39,
              41, 45, 15, 21, 8, 18, 2, 61, 56, 14};
        rho_off = t[i];
    endfunction

    // One Keccak-f round with a given round constant.
    function automatic state_t keccak_round(input state_t s, input logic [63:0] rc);
        logic [63:0] a [25];
        logic [63:0] b [25];
        logic [63:0] c [5];
        logic [63:0] d [5];
        state_t      o;
        for (int i = 0; i < 25; i++) a[i] = s[64*i +: 64];
        for (int x = 0; x < 5; x++)
            c[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
        for (int x = 0; x < 5; x++)
            d[x] = c[(x+4)%5] ^ rotl(c[(x+1)%5], 1);
        for (int i = 0; i < 25; i++) a[i] = a[i] ^ d[i%5];
        for (int x = 0; x < 5; x++)
            for (int y = 0; y < 5; y++)
                b[lidx(y, (2*x + 3*y) % 5)] = rotl(a[lidx(x, y)], rho_off(lidx(x, y)));
        for (int y = 0; y < 5; y++)
            for (int x = 0; x < 5; x++)
                a[lidx(x, y)] = b[lidx(x, y)] ^
                    (~b[lidx((x+1)%5, y)] & b[lidx((x+2)%5, y)]);
        a[0] = a[0] ^ rc;
        for (int i = 0; i < 25; i++) o[64*i +: 64] = a[i];
        keccak_round = o;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ksh_datapath.sv =====
// State register, round unit and byte access for the Keccak sponge.
`timescale 1ns / 1ps
`default_nettype none
module ksh_datapath
    import ksh_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire dp_cmd_t    cmd,
    input  wire logic [7:0] rate_eff,
    input  wire logic [7:0] read_pos,
    output dp_status_t      status
);
    localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    state_t      st_reg, st_next;
    logic        busy_reg, busy_next;
    logic [RW-1:0] rnd_reg, rnd_next;
    logic [7:0]  lfsr_reg, lfsr_next;
    logic [63:0] rc;
    logic [7:0]  lf;
    logic [10:0] top_bit;

    // Round constant from the LFSR, seven steps per round.
    always_comb begin
        rc = '0;
        lf = lfsr_reg;
        for (int j = 0; j < 7; j++) begin
            if (lf[0]) rc[(1 << j) - 1] = 1'b1;
            lf = lf[7] ? ({lf[6:0], 1'b0} ^ LFSR_POLY) : {lf[6:0], 1'b0};
        end
    end

    always_comb begin
        st_next   = st_reg;
        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        lfsr_next = lfsr_reg;
        top_bit   = {rate_eff - 8'd1, 3'b111};
        if (cmd.clear) begin
            st_next = '0;
        end else if (busy_reg) begin
            st_next   = keccak_round(st_reg, rc);
            lfsr_next = lf;
            if (rnd_reg == RW'(ROUNDS - 1)) begin
                busy_next = 1'b0;
            end else begin
                rnd_next = rnd_reg + 1'b1;
            end
        end else begin
            if (cmd.xor_en && cmd.xor_pos < STATE_BYTES)
                st_next[{cmd.xor_pos, 3'b000} +: 8] = st_reg[{cmd.xor_pos, 3'b000} +: 8]
                                                      ^ cmd.xor_val;
            if (cmd.top_en)
                st_next[top_bit] = st_reg[top_bit] ^ 1'b1;
            if (cmd.perm_start) begin
                busy_next = 1'b1;
                rnd_next  = '0;
                lfsr_next = LFSR_SEED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= '0;
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
            lfsr_reg <= LFSR_SEED;
        end else begin
            st_reg   <= st_next;
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            lfsr_reg <= lfsr_next;
        end
    end

    assign status.perm_busy = busy_reg;
    assign status.read_data = st_reg[{read_pos, 3'b000} +: 8];
endmodule
`default_nettype wire

// ===== hdl/ksh_ctrl.sv =====
// Sequencer for absorb, padding, squeeze and clear of the Keccak sponge.
`timescale 1ns / 1ps
`default_nettype none
module ksh_ctrl
    import ksh_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] in_byte,
    input  wire logic [3:0] in_count,
    input  wire logic       in_last,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_byte,
    output logic            m_last,
    input  wire logic [7:0] rate_eff,
    input  wire logic [7:0] suffix_cfg,
    input  wire logic [6:0] digest_eff,
    output dp_cmd_t         cmd,
    output logic [7:0]      read_pos,
    input  wire dp_status_t status
);
    ctrl_state_t state_reg, state_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  ab_reg, ab_next;       // byte to absorb
    logic        fin_reg, fin_next;     // padding follows absorb
    logic        doab_reg, doab_next;   // absorb a byte first
    logic [7:0]  suf_reg, suf_next;
    logic [6:0]  cnt_reg, cnt_next;     // digest bytes left
    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        ol_reg, ol_next;
    logic [15:0] merged;
    logic [7:0]  mask;
    logic        busy;

    assign busy = status.perm_busy;
    assign mask = 8'hFF >> (4'd8 - in_count);
    assign merged = {8'h00, in_byte & mask} | ({8'h00, suffix_cfg} << in_count[2:0]);
    assign read_pos = pos_reg;

    always_comb begin
        state_next = state_reg;
        pos_next = pos_reg; ab_next = ab_reg; fin_next = fin_reg; doab_next = doab_reg;
        suf_next = suf_reg; cnt_next = cnt_reg;
        ov_next = ov_reg; ob_next = ob_reg; ol_next = ol_reg;
        if (ov_reg && m_tready) ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PRE_PERM;
                    if (in_count >= 4'd8) begin
                        doab_next = 1'b1; ab_next = in_byte;
                        fin_next = in_last; suf_next = suffix_cfg;
                        if (!in_last) state_next = ST_PRE_PERM;
                    end else if (in_count == 4'd0) begin
                        doab_next = 1'b0; fin_next = in_last; suf_next = suffix_cfg;
                        if (!in_last) state_next = ST_IDLE;
                    end else begin
                        fin_next = 1'b1;
                        doab_next = merged[15:8] != 8'h00;
                        ab_next = merged[7:0];
                        suf_next = (merged[15:8] != 8'h00) ? merged[15:8] : merged[7:0];
                    end
                end
            end
            ST_PRE_PERM: begin
                if (!busy) begin
                    if (pos_reg >= rate_eff) begin
                        pos_next = '0;
                    end else begin
                        state_next = doab_reg ? ST_ABSORB : ST_PAD_SUFFIX;
                        if (!doab_reg && suf_reg == 8'h00) suf_next = DELIM_DEFAULT;
                    end
                end
            end
            ST_ABSORB: begin
                pos_next = pos_reg + 8'd1;
                state_next = ST_POST_PERM;
            end
            ST_POST_PERM: begin
                if (!busy) begin
                    if (pos_reg >= rate_eff) pos_next = '0;
                    else if (fin_reg) begin
                        state_next = ST_PRE_PERM; doab_next = 1'b0;
                        if (suf_reg == 8'h00) suf_next = DELIM_DEFAULT;
                    end else state_next = ST_IDLE;
                end
            end
            ST_PAD_SUFFIX: begin
                state_next = (suf_reg >= PAD_TOP && pos_reg == rate_eff - 8'd1)
                             ? ST_PAD_EXTRA : ST_PAD_FINAL;
            end
            ST_PAD_EXTRA: if (!busy) state_next = ST_PAD_FINAL;
            ST_PAD_FINAL: begin
                if (!busy) begin
                    state_next = ST_SQ_PERM; pos_next = '0; cnt_next = digest_eff;
                end
            end
            ST_SQ_PERM: if (!busy) state_next = ST_SQ_OUT;
            ST_SQ_OUT: begin
                if (!ov_reg || m_tready) begin
                    if (pos_reg == rate_eff) begin
                        pos_next = '0; state_next = ST_SQ_PERM;
                    end else begin
                        ov_next = 1'b1;
                        ob_next = (pos_reg < STATE_BYTES) ? status.read_data : 8'h00;
                        ol_next = cnt_reg == 7'd1;
                        pos_next = pos_reg + 8'd1;
                        cnt_next = cnt_reg - 7'd1;
                        if (cnt_reg == 7'd1) state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                pos_next = '0; state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_tready = (state_reg == ST_IDLE);
        cmd.xor_pos = pos_reg;
        unique case (state_reg)
            ST_PRE_PERM:   cmd.perm_start = !busy && pos_reg >= rate_eff;
            ST_ABSORB: begin
                cmd.xor_en = 1'b1; cmd.xor_val = ab_reg;
                cmd.perm_start = (pos_reg + 8'd1) >= rate_eff;
            end
            ST_PAD_SUFFIX: begin
                cmd.xor_en = 1'b1; cmd.xor_val = suf_reg;
                cmd.perm_start = suf_reg >= PAD_TOP && pos_reg == rate_eff - 8'd1;
            end
            ST_PAD_FINAL: begin
                cmd.top_en = !busy; cmd.perm_start = !busy;
            end
            ST_SQ_OUT: cmd.perm_start = (!ov_reg || m_tready) && pos_reg == rate_eff;
            ST_CLEAR:  cmd.clear = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; pos_reg <= '0; ov_reg <= 1'b0;
            fin_reg <= 1'b0; doab_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            state_reg <= state_next; pos_reg <= pos_next; ov_reg <= ov_next;
            fin_reg <= fin_next; doab_reg <= doab_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ab_reg <= ab_next; suf_reg <= suf_next; ob_reg <= ob_next; ol_reg <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign m_byte = ob_reg;
    assign m_last = ol_reg;
endmodule
`default_nettype wire

// ===== hdl/keccak_sponge_hash_top.sv =====
// Top level of the Keccak sponge hash block.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   s_ channel: one message byte per transaction. tdata = data_byte [7:0],
//   bit_count [11:8]; tlast = end_of_message. A partial byte (1-7 bits) ends
//   the message; bit_count 0 with tlast is an empty final item.
//   m_ channel: one digest byte per transaction in tdata, tlast on the last.
//   cfg channel: cfg_index 0 rate_bytes, 1 suffix_bits, 2 digest_bytes;
//   write only while idle.
// Flow: a full message byte passes through accept, position check,
//   absorb and wrap-up; a byte that fills the rate block also starts
//   the permutation, run one round per cycle by the round unit.
//   Padding ends in a permutation, then one digest byte per cycle while
//   m_tready is high, with a permutation every rate_bytes output bytes.
// Reset: aresetn low clears the state, the position and the registers to
//   rate 136, suffix 0x06, digest 32 (SHA3-256).
// Stall: when m_tready is low the digest byte holds and squeeze pauses;
//   no new input is taken until the last digest byte sits in the output
//   register and the state has been cleared.
module keccak_sponge_hash_top
    import ksh_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // data_byte [7:0], bit_count [11:8], zero [15:12]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // digest_byte [7:0]
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    logic [7:0] rate_reg, suffix_reg;
    logic [6:0] digest_reg;
    logic [7:0] rate_eff;
    logic [6:0] digest_eff;
    logic [7:0] read_pos;
    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // Capture configuration writes; unknown indexes drop.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg   <= RATE_RESET;
            suffix_reg <= SUFFIX_RESET;
            digest_reg <= DIGEST_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RATE:   rate_reg   <= cfg_data;
                CFG_SUFFIX: suffix_reg <= cfg_data;
                CFG_DIGEST: digest_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Clamp out-of-range settings.
    assign rate_eff = (rate_reg == 8'd0) ? 8'd1 :
                      (rate_reg > STATE_BYTES) ? STATE_BYTES : rate_reg;
    assign digest_eff = (digest_reg == 7'd0) ? 7'd1 :
                        (digest_reg > DIGEST_MAX) ? DIGEST_MAX : digest_reg;

    ksh_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_byte    (s_tdata[7:0]),
        .in_count   (s_tdata[11:8]),
        .in_last    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_byte     (m_tdata),
        .m_last     (m_tlast),
        .rate_eff   (rate_eff),
        .suffix_cfg (suffix_reg),
        .digest_eff (digest_eff),
        .cmd        (cmd),
        .read_pos   (read_pos),
        .status     (status)
    );

    ksh_datapath #(.ROUNDS(ROUNDS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rate_eff (rate_eff),
        .read_pos (read_pos),
        .status   (status)
    );
endmodule
`default_nettype wire
